[hw/rtl/gzhp_pkg.sv]
`default_nettype none
package gzhp_pkg;

  typedef enum logic [3:0] {
    ST_MORE     = 4'd0,
    ST_DONE     = 4'd1,
    ST_CLEAN    = 4'd2,
    ST_TRUNC    = 4'd3,
    ST_MAGIC    = 4'd4,
    ST_METHOD   = 4'd5,
    ST_RESERVED = 4'd6,
    ST_HCRC     = 4'd7,
    ST_WINDOW   = 4'd8,
    ST_CHECK    = 4'd9,
    ST_DICT     = 4'd10,
    ST_IDLE     = 4'd11
  } status_t;

  localparam logic [7:0]  GZ_ID1       = 8'h1f;
  localparam logic [7:0]  GZ_ID2       = 8'h8b;
  localparam logic [7:0]  CM_DEFLATE   = 8'h08;
  localparam logic [3:0]  ZL_CM        = 4'h8;
  localparam logic [3:0]  ZL_CINFO_MAX = 4'h7;
  localparam logic [7:0]  FL_HCRC      = 8'h02;
  localparam logic [7:0]  FL_EXTRA     = 8'h04;
  localparam logic [7:0]  FL_NAME      = 8'h08;
  localparam logic [7:0]  FL_COMMENT   = 8'h10;
  localparam logic [7:0]  FL_RESERVED  = 8'he0;
  localparam logic [7:0]  ZL_FDICT     = 8'h20;
  localparam logic [3:0]  GZ_FIXED_LAST = 4'd9;
  localparam logic [31:0] CRC_POLY     = 32'hedb88320;

  // one byte of the reflected CRC-32, pre and post inverted
  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

  // {cmf,flg} divisible by 31: 2^5 = 1 mod 31, so fold 5-bit digits
  function automatic logic fcheck_ok(input logic [7:0] cmf, input logic [7:0] flg);
    logic [15:0] v;
    logic [6:0]  s;
    logic [5:0]  t;
    v = {cmf, flg};
    s = {2'd0, v[4:0]} + {2'd0, v[9:5]} + {2'd0, v[14:10]} + {6'd0, v[15]};
    t = {1'b0, s[4:0]} + {4'd0, s[6:5]};
    return (t == 6'd0) || (t == 6'd31);
  endfunction

endpackage
`default_nettype wire

[hw/rtl/gzhp_parse.sv]
`default_nettype none
module gzhp_parse (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire logic [7:0]       data_byte,
  input  wire logic             stream_end,
  input  wire logic             restart,
  input  wire logic             format_is_gzip,
  output gzhp_pkg::status_t     status
);

  typedef enum logic [2:0] {
    PH_FIXED   = 3'd0,
    PH_XLEN    = 3'd1,
    PH_EXTRA   = 3'd2,
    PH_NAME    = 3'd3,
    PH_COMMENT = 3'd4,
    PH_HCRC    = 3'd5,
    PH_IDLE    = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt, e_phase;
  logic [3:0]  idx_r, idx_nxt, e_idx;
  logic [7:0]  flag_r, flag_nxt, e_flag;
  logic [7:0]  first_r, first_nxt, e_first;
  logic [15:0] extra_r, extra_nxt, e_extra, extra_dec;
  logic [31:0] crc_r, crc_nxt, e_crc, crc_upd;
  logic [7:0]  crc_low_r, crc_low_nxt, e_crc_low;

  function automatic phase_t next_section(input phase_t from, input logic [7:0] fl);
    if (from < PH_XLEN && (fl & gzhp_pkg::FL_EXTRA) != 8'd0) return PH_XLEN;
    if (from < PH_NAME && (fl & gzhp_pkg::FL_NAME) != 8'd0) return PH_NAME;
    if (from < PH_COMMENT && (fl & gzhp_pkg::FL_COMMENT) != 8'd0) return PH_COMMENT;
    if (from < PH_HCRC && (fl & gzhp_pkg::FL_HCRC) != 8'd0) return PH_HCRC;
    return PH_IDLE;
  endfunction

  always_comb begin
    if (restart) begin
      e_phase   = PH_FIXED;
      e_idx     = 4'd0;
      e_flag    = 8'd0;
      e_first   = 8'd0;
      e_extra   = 16'd0;
      e_crc     = 32'd0;
      e_crc_low = 8'd0;
    end else begin
      e_phase   = phase_r;
      e_idx     = idx_r;
      e_flag    = flag_r;
      e_first   = first_r;
      e_extra   = extra_r;
      e_crc     = crc_r;
      e_crc_low = crc_low_r;
    end
  end

  assign crc_upd   = gzhp_pkg::crc_step(e_crc, data_byte);
  assign extra_dec = e_extra - 16'd1;

  always_comb begin
    phase_nxt   = e_phase;
    idx_nxt     = e_idx;
    flag_nxt    = e_flag;
    first_nxt   = e_first;
    extra_nxt   = e_extra;
    crc_nxt     = e_crc;
    crc_low_nxt = e_crc_low;
    status      = gzhp_pkg::ST_MORE;
    if (stream_end) begin
      if (e_phase == PH_IDLE) status = gzhp_pkg::ST_IDLE;
      else if (e_phase == PH_FIXED && e_idx == 4'd0) status = gzhp_pkg::ST_CLEAN;
      else status = gzhp_pkg::ST_TRUNC;
      phase_nxt = PH_IDLE;
    end else begin
      case (e_phase)
        PH_FIXED: begin
          if (!format_is_gzip) begin
            if (e_idx == 4'd0) begin
              first_nxt = data_byte;
              idx_nxt   = 4'd1;
              if (data_byte[3:0] != gzhp_pkg::ZL_CM) begin
                status    = gzhp_pkg::ST_METHOD;
                phase_nxt = PH_IDLE;
              end else if (data_byte[7:4] > gzhp_pkg::ZL_CINFO_MAX) begin
                status    = gzhp_pkg::ST_WINDOW;
                phase_nxt = PH_IDLE;
              end
            end else begin
              phase_nxt = PH_IDLE;
              if (!gzhp_pkg::fcheck_ok(e_first, data_byte)) status = gzhp_pkg::ST_CHECK;
              else if ((data_byte & gzhp_pkg::ZL_FDICT) != 8'd0) status = gzhp_pkg::ST_DICT;
              else status = gzhp_pkg::ST_DONE;
            end
          end else begin
            crc_nxt = crc_upd;
            case (e_idx)
              4'd0: first_nxt = data_byte;
              4'd1: begin
                if (e_first != gzhp_pkg::GZ_ID1 || data_byte != gzhp_pkg::GZ_ID2) begin
                  status = gzhp_pkg::ST_MAGIC;
                end
              end
              4'd2: begin
                if (data_byte != gzhp_pkg::CM_DEFLATE) status = gzhp_pkg::ST_METHOD;
              end
              4'd3: begin
                flag_nxt = data_byte;
                if ((data_byte & gzhp_pkg::FL_RESERVED) != 8'd0) status = gzhp_pkg::ST_RESERVED;
              end
              default: ;
            endcase
            if (status != gzhp_pkg::ST_MORE) begin
              phase_nxt = PH_IDLE;
            end else if (e_idx >= gzhp_pkg::GZ_FIXED_LAST) begin
              idx_nxt   = 4'd0;
              phase_nxt = next_section(PH_FIXED, e_flag);
            end else begin
              idx_nxt = e_idx + 4'd1;
            end
          end
        end
        PH_XLEN: begin
          crc_nxt = crc_upd;
          if (e_idx == 4'd0) begin
            extra_nxt = {8'd0, data_byte};
            idx_nxt   = 4'd1;
          end else begin
            extra_nxt = {data_byte, e_extra[7:0]};
            idx_nxt   = 4'd0;
            if ({data_byte, e_extra[7:0]} == 16'd0) phase_nxt = next_section(PH_EXTRA, e_flag);
            else phase_nxt = PH_EXTRA;
          end
        end
        PH_EXTRA: begin
          crc_nxt   = crc_upd;
          extra_nxt = extra_dec;
          if (extra_dec == 16'd0) begin
            idx_nxt   = 4'd0;
            phase_nxt = next_section(PH_EXTRA, e_flag);
          end
        end
        PH_NAME, PH_COMMENT: begin
          crc_nxt = crc_upd;
          if (data_byte == 8'd0) begin
            idx_nxt   = 4'd0;
            phase_nxt = next_section(e_phase, e_flag);
          end
        end
        PH_HCRC: begin
          if (e_idx == 4'd0) begin
            crc_low_nxt = data_byte;
            idx_nxt     = 4'd1;
          end else begin
            phase_nxt = PH_IDLE;
            if ({data_byte, e_crc_low} != e_crc[15:0]) status = gzhp_pkg::ST_HCRC;
            else status = gzhp_pkg::ST_DONE;
          end
        end
        default: status = gzhp_pkg::ST_IDLE;
      endcase
      if (status == gzhp_pkg::ST_MORE && phase_nxt == PH_IDLE) status = gzhp_pkg::ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_FIXED;
      idx_r     <= 4'd0;
      flag_r    <= 8'd0;
      first_r   <= 8'd0;
      extra_r   <= 16'd0;
      crc_r     <= 32'd0;
      crc_low_r <= 8'd0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      flag_r    <= flag_nxt;
      first_r   <= first_nxt;
      extra_r   <= extra_nxt;
      crc_r     <= crc_nxt;
      crc_low_r <= crc_low_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/gzip_zlib_header_parser.sv]
`default_nettype none
// gzip / zlib header checker, one compressed byte per request. A request is
// captured in an input register, then its status is worked out combinationally
// (header state update plus one byte-wide CRC-32 step) and lands in the
// result register when that register is free or being read: the status passes
// through both registers, throughput one request per clock under no back-pressure.
// A new request is taken while a result waits, if the input register is empty.
// Status per request: 0 more, 1 header done, 2 clean end, 3 truncated,
// 4..10 errors (magic, method, reserved, hcrc, window, check, dict), 11 idle.
// After done, error or end of input the block answers idle until restart.
// Write cfg_format_is_gzip only while the block is empty.
module gzip_zlib_header_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_format_is_gzip,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_stream_end,
  input  wire logic       in_restart,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      out_status,
  output logic            out_checksum_start
);

  logic              fmt_r;
  logic              in_valid_r;
  logic [7:0]        in_data_r;
  logic              in_eoi_r;
  logic              in_restart_r;
  logic              out_valid_r;
  logic [3:0]        out_status_r;
  logic              out_cks_r;
  logic              advance;
  gzhp_pkg::status_t status;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_checksum_start = out_cks_r;

  gzhp_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (advance),
    .data_byte      (in_data_r),
    .stream_end     (in_eoi_r),
    .restart        (in_restart_r),
    .format_is_gzip (fmt_r),
    .status         (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= 1'b1;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) fmt_r <= cfg_format_is_gzip;
      if (in_valid && in_ready) in_valid_r <= 1'b1;
      else if (advance) in_valid_r <= 1'b0;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r    <= in_data_byte;
      in_eoi_r     <= in_stream_end;
      in_restart_r <= in_restart;
    end
    if (advance) begin
      out_status_r <= status;
      out_cks_r    <= !fmt_r;
    end
  end

endmodule
`default_nettype wire
